>>> design/drpf_pkg.sv
// ---------------------------------------------------------------------------
// drpf_pkg
// shared types, codes and constants of the dna repeat period finder
// ---------------------------------------------------------------------------
package drpf_pkg;

    // input transfer: one load or one query
    typedef struct packed {
        logic        mode;
        logic [15:0] position;
        logic [7:0]  base_char;
    } drpf_in_t;

    // output transfer: one query result
    typedef struct packed {
        logic [10:0] best_score;
        logic [7:0]  best_period;
        logic        blank;
    } drpf_out_t;

    // per-cycle control of the score unit, aligned with memory read data
    typedef struct packed {
        logic       start;
        logic       valid;
        logic       last;
        logic       count;
        logic [7:0] period;
    } drpf_score_ctl_t;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // word index of the only register
    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic [10:0] WINDOW_LEN_RESET = 11'd32;

    localparam logic [1:0] CODE_OTHER = 2'd0;
    localparam logic [1:0] CODE_C     = 2'd1;
    localparam logic [1:0] CODE_G     = 2'd2;
    localparam logic [1:0] CODE_T     = 2'd3;

    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    // offset d = 4*o + f
    localparam logic [5:0] OFFSET_LAST = 6'd61;
    localparam logic [1:0] FRAME_LAST  = 2'd3;
    localparam logic [7:0] NO_PERIOD   = 8'd251;

    // hysteresis ratio 11/10
    localparam int unsigned HYST_LO = 10;
    localparam int unsigned HYST_HI = 11;

    function automatic logic [1:0] code_of(input logic [7:0] ch);
        logic [1:0] code;
        unique case (ch)
            CHAR_C:  code = CODE_C;
            CHAR_G:  code = CODE_G;
            CHAR_T:  code = CODE_T;
            default: code = CODE_OTHER;
        endcase
        return code;
    endfunction

endpackage

>>> design/drpf_base_mem.sv
// ---------------------------------------------------------------------------
// drpf_base_mem
// base store: 2-bit codes, one write port and two registered read ports
// ---------------------------------------------------------------------------
module drpf_base_mem #(
    parameter int unsigned AW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [1:0]    wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [1:0]    qa,
    output logic [1:0]    qb
);

    logic [1:0] mem [2**AW];
    logic [1:0] qa_reg;
    logic [1:0] qb_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        qa_reg <= mem[raddr_a];
        qb_reg <= mem[raddr_b];
    end

    assign qa = qa_reg;
    assign qb = qb_reg;

endmodule

>>> design/drpf_score_unit.sv
// ---------------------------------------------------------------------------
// drpf_score_unit
// bit-serial match counter and hysteresis winner selection
// ---------------------------------------------------------------------------
module drpf_score_unit #(
    parameter int unsigned CW = 11
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  drpf_pkg::drpf_score_ctl_t ctl,
    input  logic [1:0]                qa,
    input  logic [1:0]                qb,
    output logic [CW-1:0]             best_score,
    output logic [7:0]                best_period
);

    localparam int unsigned MW = CW + 4;

    logic [CW-1:0] acc_reg;
    logic [CW-1:0] acc_next;
    logic [CW-1:0] best_reg;
    logic [CW-1:0] best_next;
    logic [7:0]    bestd_reg;
    logic [7:0]    bestd_next;
    logic [CW-1:0] s;
    logic          match;
    logic [MW-1:0] s10;
    logic [MW-1:0] s11;
    logic [MW-1:0] b10;
    logic [MW-1:0] b11;
    logic          qualifies;
    logic          win;

    assign match = ctl.count && (qa == qb);
    assign s     = acc_reg + CW'(match);

    assign s10 = MW'(s) * MW'(drpf_pkg::HYST_LO);
    assign s11 = MW'(s) * MW'(drpf_pkg::HYST_HI);
    assign b10 = MW'(best_reg) * MW'(drpf_pkg::HYST_LO);
    assign b11 = MW'(best_reg) * MW'(drpf_pkg::HYST_HI);

    // s >= floor(10*best/11)  <=>  10*best < 11*s + 11
    assign qualifies = b10 < (s11 + MW'(drpf_pkg::HYST_HI));
    // s >= ceil(11*best/10)   <=>  10*s >= 11*best
    assign win = qualifies && ((ctl.period < bestd_reg) || (s10 >= b11));

    always_comb
    begin
        acc_next   = acc_reg;
        best_next  = best_reg;
        bestd_next = bestd_reg;
        if (ctl.start)
        begin
            acc_next   = '0;
            best_next  = '0;
            bestd_next = drpf_pkg::NO_PERIOD;
        end
        else if (ctl.valid)
        begin
            if (ctl.last)
            begin
                acc_next = '0;
                if (win)
                begin
                    best_next  = s;
                    bestd_next = ctl.period;
                end
            end
            else
            begin
                acc_next = s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            best_reg  <= '0;
            bestd_reg <= drpf_pkg::NO_PERIOD;
        end
        else
        begin
            acc_reg   <= acc_next;
            best_reg  <= best_next;
            bestd_reg <= bestd_next;
        end
    end

    assign best_score  = best_reg;
    assign best_period = bestd_reg;

endmodule

>>> design/dna_repeat_period_finder.sv
// ---------------------------------------------------------------------------
// dna_repeat_period_finder
// base store with repeat period search around a query position
// ---------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall / in_data) takes one transfer at a time.
//   mode load writes the 2-bit code of base_char at position and gives no
//   result. mode query gives exactly one output transfer.
//   a query first reads the aligned group of four holding position; if all
//   four are code zero the result is blank and no scan is run. otherwise
//   every offset 1..247 is scored one base pair per cycle through the two
//   read ports of the base store over a window of W base pairs, W being
//   window_len clamped to MAX_WINDOW and rounded down to a multiple of four.
//   in_stall stays high from a query transfer until its result is loaded into
//   the output register; the next load or query is then taken at once even if
//   the result still waits behind out_stall.
//   out_valid holds with a stable out_data while out_stall is high; a finished
//   query waits in its last state until the output register is free.
//   reset clears the control state and sets window_len to 32; the base store
//   has no reset and must be loaded before it is queried.
//   window_len is written through the apb port; the user must write it only
//   while the block is idle, the block itself does not enforce this.
// ---------------------------------------------------------------------------
module dna_repeat_period_finder #(
    parameter int unsigned SEQ_DEPTH  = 65536,
    parameter int unsigned MAX_WINDOW = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  drpf_pkg::drpf_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output drpf_pkg::drpf_out_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int unsigned AW = $clog2(SEQ_DEPTH);
    localparam int unsigned XW = (AW > 16) ? AW : 16;
    localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
    localparam int unsigned EW = (CW > 11) ? CW : 11;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_BLANK  = 6'b000010,
        ST_BLANKW = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_SCANW  = 6'b010000,
        ST_DONE   = 6'b100000
    } drpf_state_t;

    drpf_state_t state_reg, state_next;

    // configuration
    logic [10:0] window_len_reg;
    logic        cfg_write;

    // query context and counters
    logic [AW-1:0] pos_reg, pos_next;
    logic          k_reg, k_next;
    logic          nz_reg, nz_next;
    logic          blank_reg, blank_next;
    logic [1:0]    f_reg, f_next;
    logic [5:0]    o_reg, o_next;
    logic [CW-1:0] i_reg, i_next;

    // output register
    logic                out_valid_reg;
    drpf_pkg::drpf_out_t out_data_reg;
    logic                out_load;

    // score unit control, registered to line up with the read data
    drpf_pkg::drpf_score_ctl_t ctl_reg, ctl_next;

    logic          in_accept;
    logic          load_accept;
    logic          query_accept;
    logic [XW-1:0] in_pos_x;
    logic [AW-1:0] in_pos;
    logic [EW-1:0] wl_x;
    logic [EW-1:0] wl_clamp;
    logic [CW-1:0] eff;
    logic          w_zero;
    logic          last_i;
    logic          last_d;
    logic [7:0]    period;
    logic [AW-1:0] grp;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [1:0]    qa;
    logic [1:0]    qb;
    logic          grp_nz;
    logic [CW-1:0] best_score;
    logic [7:0]    best_period;

    // apb register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == drpf_pkg::REG_WINDOW_LEN);
    assign prdata    = (paddr[2] == drpf_pkg::REG_WINDOW_LEN) ? {21'd0, window_len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= drpf_pkg::WINDOW_LEN_RESET;
        end
        else if (cfg_write)
        begin
            window_len_reg <= pwdata[10:0];
        end
    end

    // effective window: clamp, then round down to a multiple of four
    assign wl_x     = EW'(window_len_reg);
    assign wl_clamp = (wl_x > EW'(MAX_WINDOW)) ? EW'(MAX_WINDOW) : wl_x;
    assign eff      = {wl_clamp[CW-1:2], 2'b00};
    assign w_zero   = (eff == '0);

    // input handshake
    assign in_stall     = (state_reg != ST_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign load_accept  = in_accept && (in_data.mode == drpf_pkg::MODE_LOAD);
    assign query_accept = in_accept && (in_data.mode == drpf_pkg::MODE_QUERY);

    // store addresses wrap modulo the depth
    assign in_pos_x = XW'(in_data.position);
    assign in_pos   = in_pos_x[AW-1:0];

    // offset walk: frame outer, offset inner, d = 4*o + f
    assign period = {o_reg, f_reg};
    assign last_i = w_zero || (i_reg == CW'(eff - 1'b1));
    assign last_d = (f_reg == drpf_pkg::FRAME_LAST) && (o_reg == drpf_pkg::OFFSET_LAST);

    // read address select: group check or window pair
    assign grp = {pos_reg[AW-1:2], 2'b00};

    always_comb
    begin
        if (state_reg == ST_BLANK)
        begin
            raddr_a = grp + AW'({k_reg, 1'b0});
            raddr_b = grp + AW'({k_reg, 1'b1});
        end
        else
        begin
            raddr_a = pos_reg + AW'(i_reg);
            raddr_b = pos_reg + AW'(i_reg) + AW'(period);
        end
    end

    drpf_base_mem #(
        .AW(AW)
    ) u_mem (
        .clk    (clk),
        .we     (load_accept),
        .waddr  (in_pos),
        .wdata  (drpf_pkg::code_of(in_data.base_char)),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .qa     (qa),
        .qb     (qb)
    );

    drpf_score_unit #(
        .CW(CW)
    ) u_score (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_reg),
        .qa         (qa),
        .qb         (qb),
        .best_score (best_score),
        .best_period(best_period)
    );

    assign grp_nz   = (qa != drpf_pkg::CODE_OTHER) || (qb != drpf_pkg::CODE_OTHER);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        nz_next    = nz_reg;
        blank_next = blank_reg;
        f_next     = f_reg;
        o_next     = o_reg;
        i_next     = i_reg;
        ctl_next   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_accept)
                begin
                    pos_next       = in_pos;
                    k_next         = 1'b0;
                    ctl_next.start = 1'b1;
                    state_next     = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                // first pair of the group arrives while the second is issued
                k_next = 1'b1;
                if (k_reg)
                begin
                    nz_next    = grp_nz;
                    state_next = ST_BLANKW;
                end
            end
            ST_BLANKW:
            begin
                blank_next = !(nz_reg || grp_nz);
                // scan starts at d = 4 in frame zero, skipping d = 0
                f_next = 2'd0;
                o_next = 6'd1;
                i_next = '0;
                if (nz_reg || grp_nz)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                ctl_next.valid  = 1'b1;
                ctl_next.last   = last_i;
                ctl_next.count  = !w_zero;
                ctl_next.period = period;
                if (last_i)
                begin
                    i_next = '0;
                    if (o_reg == drpf_pkg::OFFSET_LAST)
                    begin
                        o_next = 6'd0;
                        f_next = f_reg + 2'd1;
                    end
                    else
                    begin
                        o_next = o_reg + 6'd1;
                    end
                    if (last_d)
                    begin
                        state_next = ST_SCANW;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_SCANW:
            begin
                // last offset is scored in this cycle
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ctl_reg   <= '0;
            k_reg     <= 1'b0;
            nz_reg    <= 1'b0;
            blank_reg <= 1'b0;
            f_reg     <= 2'd0;
            o_reg     <= 6'd0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ctl_reg   <= ctl_next;
            k_reg     <= k_next;
            nz_reg    <= nz_next;
            blank_reg <= blank_next;
            f_reg     <= f_next;
            o_reg     <= o_next;
            i_reg     <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
    end

    // output register, held while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (blank_reg)
            begin
                out_data_reg.best_score  <= 11'd0;
                out_data_reg.best_period <= 8'd0;
                out_data_reg.blank       <= 1'b1;
            end
            else
            begin
                out_data_reg.best_score  <= 11'(best_score);
                out_data_reg.best_period <= best_period;
                out_data_reg.blank       <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // no store write while a query is running
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !load_accept)
        else $error("base store written during a query");

    // a query transfer always starts with the group check
    a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
        query_accept |=> (state_reg == ST_BLANK) && ctl_reg.start)
        else $error("query did not start the group check");

    // a finished scan always holds a real offset
    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && !blank_reg) |-> (best_period != 8'd0)
            && (best_period <= 8'd247))
        else $error("chosen period out of range");

    // score unit sees data only during the scan and its drain cycle
    a_ctl_window: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid |-> ((state_reg == ST_SCAN) || (state_reg == ST_SCANW)))
        else $error("score data outside the scan");

endmodule

>>> verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the dna repeat period finder: base loads and window
// queries go in over the valid/stall input channel, every query result is
// compared field by field against a behavioral period search kept in step
// with the loads or a typed row, and window_len is exercised through the apb port
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SEQ_DEPTH    = 65536;
    localparam int unsigned MAX_WINDOW   = 1024;
    // largest offset visited by a query: d = 4*o + f at its upper ends
    localparam int unsigned MAX_OFFSET   = 4 * drpf_pkg::OFFSET_LAST + drpf_pkg::FRAME_LAST;
    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned QUIET_ITEMS  = 150;
    localparam int unsigned NARROW_CAP   = 15;
    localparam int unsigned WIDE_CAP     = 40;
    localparam int unsigned WIDE_LEN     = 64;
    localparam int unsigned LOAD_SETTLE  = 8;
    localparam int unsigned END_SETTLE   = 40;
    // a long correct query runs with no transfer on either channel
    localparam int unsigned STALL_LIMIT  = 100000;
    localparam logic [2:0]  WINDOW_ADDR  = {drpf_pkg::REG_WINDOW_LEN, 2'b00};

    localparam drpf_pkg::drpf_out_t BLANK_RESULT =
        '{best_score: 11'd0, best_period: 8'd0, blank: 1'b1};
    localparam drpf_pkg::drpf_out_t NOT_TYPED = '0;

    // one row of the directed part; typed rows carry their own result
    typedef struct {
        logic                mode;
        logic [15:0]         position;
        logic [7:0]          base_char;
        bit                  typed;
        drpf_pkg::drpf_out_t want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    drpf_pkg::drpf_in_t  in_data;
    logic                out_valid;
    logic                out_stall = 1'b0;
    drpf_pkg::drpf_out_t out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // bench copy of the base store and of window_len
    logic [1:0]  base_mem [0:SEQ_DEPTH-1];
    bit          base_set [0:SEQ_DEPTH-1];
    logic [10:0] window_reg;

    // query results still owed by the block, oldest first
    drpf_pkg::drpf_out_t due_periods [$];

    int unsigned fault_count = 0;
    int unsigned sent        = 0;
    int unsigned quiet_mark  = 32'hFFFF_FFFF;
    int unsigned hold_left   = 0;
    bit          quiet       = 1'b0;
    bit          tx_gaps     = 1'b0;
    bit          rx_gaps     = 1'b0;

    // directed part, run with window_len 0 so only a query's group decides its result
    dir_row_t dir_table [23] = '{
        // top group of the store, all code zero: blank at the last address
        '{drpf_pkg::MODE_LOAD,  16'hFFFC, "A",   1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_LOAD,  16'hFFFD, 8'h00, 1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_LOAD,  16'hFFFE, 8'hFF, 1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_LOAD,  16'hFFFF, "c",   1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_QUERY, 16'hFFFF, 8'h00, 1'b1, BLANK_RESULT},
        // every letter at the bottom of the store, zero window queries
        '{drpf_pkg::MODE_LOAD,  16'h0000, drpf_pkg::CHAR_C, 1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_LOAD,  16'h0001, drpf_pkg::CHAR_G, 1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_LOAD,  16'h0002, drpf_pkg::CHAR_T, 1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_LOAD,  16'h0003, "A",   1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_QUERY, 16'h0000, 8'hFF, 1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_QUERY, 16'h0003, 8'h00, 1'b0, NOT_TYPED},
        // overwrite back to all zero codes, blank again
        '{drpf_pkg::MODE_LOAD,  16'h0000, "A",   1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_LOAD,  16'h0001, "A",   1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_LOAD,  16'h0002, "a",   1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_LOAD,  16'h0003, "X",   1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_QUERY, 16'h0002, 8'h00, 1'b1, BLANK_RESULT},
        // one live base turns the top group non-blank
        '{drpf_pkg::MODE_LOAD,  16'hFFFE, drpf_pkg::CHAR_T, 1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_QUERY, 16'hFFFC, 8'h00, 1'b0, NOT_TYPED},
        // mid store group, base_char with either top bit
        '{drpf_pkg::MODE_LOAD,  16'h7FFC, drpf_pkg::CHAR_G, 1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_LOAD,  16'h7FFD, 8'h80, 1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_LOAD,  16'h7FFE, drpf_pkg::CHAR_C, 1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_LOAD,  16'h7FFF, 8'h7F, 1'b0, NOT_TYPED},
        '{drpf_pkg::MODE_QUERY, 16'h7FFD, 8'h00, 1'b0, NOT_TYPED}
    };

    dna_repeat_period_finder #(
        .SEQ_DEPTH  (SEQ_DEPTH),
        .MAX_WINDOW (MAX_WINDOW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // behavioral model
    // -----------------------------------------------------------------------

    function automatic logic [1:0] char_code(input logic [7:0] ch);
        logic [1:0] code;
        case (ch)
            drpf_pkg::CHAR_C: code = drpf_pkg::CODE_C;
            drpf_pkg::CHAR_G: code = drpf_pkg::CODE_G;
            drpf_pkg::CHAR_T: code = drpf_pkg::CODE_T;
            default:          code = drpf_pkg::CODE_OTHER;
        endcase
        return code;
    endfunction

    // window length in bases: clamped, then rounded down to whole groups
    function automatic int unsigned window_bases();
        int unsigned w;
        w = (window_reg > MAX_WINDOW) ? MAX_WINDOW : int'(window_reg);
        return w & ~32'd3;
    endfunction

    // repeat period search at pos with the current store and window
    function automatic drpf_pkg::drpf_out_t find_period(input logic [15:0] pos);
        drpf_pkg::drpf_out_t res;
        logic [15:0]         grp;
        int unsigned         w, best, qual, best_d, d, s, f, o, i;
        bit                  empty;
        res   = '0;
        grp   = {pos[15:2], 2'b00};
        empty = 1'b1;
        for (i = 0; i < 4; i++)
            if (base_mem[16'(grp + i)] != drpf_pkg::CODE_OTHER)
                empty = 1'b0;
        if (empty)
            return BLANK_RESULT;
        w      = window_bases();
        best   = 0;
        qual   = 0;
        best_d = drpf_pkg::NO_PERIOD;
        // frame outer, offset inner, same order as the hardware scan
        for (f = 0; f <= drpf_pkg::FRAME_LAST; f++)
        begin
            for (o = 0; o <= drpf_pkg::OFFSET_LAST; o++)
            begin
                d = 4 * o + f;
                if (d == 0)
                    continue;
                s = 0;
                for (i = 0; i < w; i++)
                    if (base_mem[16'(pos + i)] == base_mem[16'(pos + i + d)])
                        s++;
                if (s < qual)
                    continue;
                // hysteresis: a smaller offset or a score 10 percent up wins
                if (d < best_d || s >= (best * drpf_pkg::HYST_HI + drpf_pkg::HYST_LO - 1)
                                       / drpf_pkg::HYST_LO)
                begin
                    best   = s;
                    best_d = d;
                    qual   = s * drpf_pkg::HYST_LO / drpf_pkg::HYST_HI;
                end
            end
        end
        res.best_score  = 11'(best);
        res.best_period = 8'(best_d);
        res.blank       = 1'b0;
        return res;
    endfunction

    // true when a query at pos only touches written entries
    function automatic bit reads_written(input logic [15:0] pos);
        logic [15:0] grp;
        int unsigned k, w;
        bit          live;
        grp  = {pos[15:2], 2'b00};
        live = 1'b0;
        for (k = 0; k < 4; k++)
        begin
            if (!base_set[16'(grp + k)])
                return 1'b0;
            if (base_mem[16'(grp + k)] != drpf_pkg::CODE_OTHER)
                live = 1'b1;
        end
        // a blank group ends the query before any window read
        if (!live)
            return 1'b1;
        w = window_bases();
        if (w != 0)
            for (k = 0; k < w + MAX_OFFSET; k++)
                if (!base_set[16'(pos + k)])
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic void report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endfunction

    // -----------------------------------------------------------------------
    // input side
    // -----------------------------------------------------------------------

    // one input transfer; model state moves at the edge that takes it
    task automatic send_transfer(input logic mode, input logic [15:0] pos,
                                 input logic [7:0] ch, input bit typed,
                                 input drpf_pkg::drpf_out_t want);
        drpf_pkg::drpf_in_t  item;
        drpf_pkg::drpf_out_t owed;
        int unsigned         gap;
        item.mode      = mode;
        item.position  = pos;
        item.base_char = ch;
        @(negedge clk);
        if (sent >= quiet_mark)
            quiet = 1'b1;
        // idle burst: valid drops here, then comes back
        if (tx_gaps && !quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        if (mode == drpf_pkg::MODE_LOAD)
        begin
            base_mem[pos] = char_code(ch);
            base_set[pos] = 1'b1;
        end
        else
        begin
            owed        = typed ? want : find_period(pos);
            due_periods = {due_periods, owed};
        end
    endtask

    task automatic load_base(input logic [15:0] pos, input logic [7:0] ch);
        send_transfer(drpf_pkg::MODE_LOAD, pos, ch, 1'b0, NOT_TYPED);
    endtask

    // queries that would touch unwritten entries are skipped
    task automatic query_at(input logic [15:0] pos);
        if (reads_written(pos))
            send_transfer(drpf_pkg::MODE_QUERY, pos, 8'($urandom), 1'b0, NOT_TYPED);
    endtask

    // sender holds off until every owed result is in, then settles
    task automatic wait_results(input int unsigned settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_periods.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // -----------------------------------------------------------------------
    // apb side
    // -----------------------------------------------------------------------

    // setup then access; the transfer completes at the edge with pready
    task automatic apb_access(input bit wr, input logic [10:0] value,
                              output logic [31:0] rdata);
        logic [31:0] junk;
        junk = $urandom;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= WINDOW_ADDR;
        // bits above the register carry noise, the block must drop them
        pwdata  <= {junk[31:11], value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_window();
        logic [31:0] rd;
        apb_access(1'b0, 11'd0, rd);
        if (rd !== {21'd0, window_reg})
            report_fault($sformatf("window_len read back %0h, expected %0h",
                                   rd, window_reg));
    endtask

    task automatic write_window(input logic [10:0] value);
        logic [31:0] rd;
        apb_access(1'b1, value, rd);
        window_reg = value;
        check_window();
    endtask

    // -----------------------------------------------------------------------
    // random stimulus helpers
    // -----------------------------------------------------------------------

    function automatic logic [7:0] random_base();
        logic [7:0] ch;
        case ($urandom_range(0, 3))
            0:       ch = "A";
            1:       ch = drpf_pkg::CHAR_C;
            2:       ch = drpf_pkg::CHAR_G;
            default: ch = drpf_pkg::CHAR_T;
        endcase
        return ch;
    endfunction

    // mostly letters, now and then any byte at all
    function automatic logic [7:0] noisy_char();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom) : random_base();
    endfunction

    function automatic logic [10:0] pick_window(input int unsigned cap);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 11'($urandom_range(0, 3));
        else if (r < 9)
            return 11'($urandom_range(4, cap));
        return 11'(cap);
    endfunction

    // load a periodic stretch with mutations, then query inside it under
    // several window settings; cap bounds the window so reads stay inside
    task automatic run_region(input int unsigned cap);
        logic [7:0]  motif [0:255];
        logic [15:0] start;
        logic [15:0] grp;
        logic [7:0]  ch;
        int unsigned period, span, len, mut, k, r, sub, n_sub, n;
        start = 16'($urandom) & 16'hFFFC;
        r     = $urandom_range(0, 9);
        if (r < 7)
            period = $urandom_range(1, 12);
        else if (r < 9)
            period = $urandom_range(13, 60);
        else
            period = $urandom_range(61, MAX_OFFSET);
        for (k = 0; k < period; k++)
            motif[k] = random_base();
        span = $urandom_range(8, 40);
        len  = span + cap + MAX_OFFSET + 4;
        mut  = $urandom_range(0, 10);
        tx_gaps = ($urandom_range(0, 1) == 1);
        for (k = 0; k < len; k++)
            load_base(16'(start + k),
                      ($urandom_range(0, 99) < mut) ? noisy_char() : motif[k % period]);
        n_sub = $urandom_range(3, 5);
        for (sub = 0; sub < n_sub; sub++)
        begin
            wait_results(LOAD_SETTLE);
            write_window(pick_window(cap));
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            n = $urandom_range(8, 20);
            repeat (n)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                begin
                    // point mutation inside the stretch between queries
                    load_base(16'(start + $urandom_range(0, len - 1)), noisy_char());
                end
                else if (r == 1)
                begin
                    // zero a random group anywhere and query it
                    grp = 16'($urandom) & 16'hFFFC;
                    for (k = 0; k < 4; k++)
                    begin
                        ch = 8'($urandom);
                        if (char_code(ch) != drpf_pkg::CODE_OTHER)
                            ch = "N";
                        load_base(16'(grp + k), ch);
                    end
                    query_at(16'(grp + $urandom_range(0, 3)));
                end
                else if (r == 2)
                begin
                    // sender holds until the block has drained
                    wait_results(0);
                    query_at(16'(start + $urandom_range(0, span)));
                end
                else
                begin
                    query_at(16'(start + $urandom_range(0, span)));
                end
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // output side
    // -----------------------------------------------------------------------

    // receiver stall in random bursts, none in the closing part
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rx_gaps && !quiet && $urandom_range(0, 5) == 0)
        begin
            hold_left = $urandom_range(1, 11) - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // every output transfer against the oldest owed result
    always @(posedge clk)
    begin : check_results
        drpf_pkg::drpf_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_periods.size() == 0)
            begin
                report_fault($sformatf(
                    "result with none owed: score %0d period %0d blank %0b",
                    out_data.best_score, out_data.best_period, out_data.blank));
            end
            else
            begin
                want = due_periods.pop_front();
                if (out_data.best_score !== want.best_score ||
                    out_data.best_period !== want.best_period ||
                    out_data.blank !== want.blank)
                    report_fault($sformatf(
                        "query result: expected score %0d period %0d blank %0b, got %0d %0d %0b",
                        want.best_score, want.best_period, want.blank,
                        out_data.best_score, out_data.best_period, out_data.blank));
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("dna_repeat_period_finder verification failed");
        $finish;
    end

    // -----------------------------------------------------------------------
    // test sequence
    // -----------------------------------------------------------------------

    initial
    begin : stimulus
        logic [15:0] start;
        logic [7:0]  motif [0:63];
        int unsigned period, k, region, rand_start;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        window_reg = drpf_pkg::WINDOW_LEN_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset value, then the low extreme for the directed part
        check_window();
        write_window(11'd0);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        foreach (dir_table[row])
            send_transfer(dir_table[row].mode, dir_table[row].position,
                          dir_table[row].base_char, dir_table[row].typed,
                          dir_table[row].want);

        // high extreme of the register, then one wide query over a
        // stretch that wraps past the top of the store
        wait_results(LOAD_SETTLE);
        write_window(11'h7FF);
        write_window(11'(WIDE_LEN));
        start  = 16'hFF00;
        period = $urandom_range(3, 40);
        for (k = 0; k < period; k++)
            motif[k] = random_base();
        motif[0] = drpf_pkg::CHAR_C;
        for (k = 0; k < WIDE_LEN + MAX_OFFSET + 4; k++)
            load_base(16'(start + k),
                      ($urandom_range(0, 49) == 0) ? noisy_char() : motif[k % period]);
        query_at(start);

        // random regions, the second one with wider windows
        wait_results(LOAD_SETTLE);
        rand_start = sent;
        quiet_mark = sent + RANDOM_ITEMS - QUIET_ITEMS;
        region     = 0;
        while (sent - rand_start < RANDOM_ITEMS)
        begin
            run_region((region == 1) ? WIDE_CAP : NARROW_CAP);
            region++;
        end

        wait_results(END_SETTLE);
        if (fault_count == 0)
            $display("dna_repeat_period_finder verification clean");
        else
            $display("dna_repeat_period_finder verification failed");
        $finish;
    end

endmodule

>>> sim.f
design/drpf_pkg.sv
design/drpf_base_mem.sv
design/drpf_score_unit.sv
design/dna_repeat_period_finder.sv
verif/testbench.sv
